// File: hw/rtl/bitmap_run_allocator_macros.svh
// Assertion helpers shared by the checker.
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BRA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_run_allocator check failed");

// Next-cycle implication.
`define BRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_run_allocator check failed");

`endif

// File: hw/rtl/bra_pkg.sv
`default_nettype none
package bra_pkg;
   localparam int MAP_BITS   = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = MAP_BITS / WORD_BITS;
   localparam int WADDR_W    = $clog2(WORD_COUNT);
   localparam int BPOS_W     = $clog2(WORD_BITS);
   localparam int IDX_W      = 12;
   localparam int LEN_W      = 13;
   localparam int PTR_W      = 13;
   localparam int OP_W       = 4;

   typedef enum logic [OP_W-1:0] {
      OP_TEST        = 4'd0,
      OP_SET_RANGE   = 4'd1,
      OP_CLEAR_RANGE = 4'd2,
      OP_SET_ALL     = 4'd3,
      OP_CLEAR_ALL   = 4'd4,
      OP_FIND_CLEAR  = 4'd5,
      OP_FIND_SET    = 4'd6,
      OP_CLAIM       = 4'd7,
      OP_FIRST_SET   = 4'd8,
      OP_FIRST_CLEAR = 4'd9,
      OP_LAST_SET    = 4'd10,
      OP_LAST_CLEAR  = 4'd11,
      OP_NEXT_SET    = 4'd12,
      OP_NEXT_CLEAR  = 4'd13,
      OP_COUNT       = 4'd14,
      OP_CHECK       = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      MD_TEST,
      MD_WRITE,
      MD_COUNT,
      MD_FIRST,
      MD_LAST,
      MD_RUN
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RD,
      ST_LD,
      ST_EX,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [WADDR_W-1:0]   addr;
      logic [WORD_BITS-1:0] wdata;
   } store_req_type;

   function automatic logic [BPOS_W:0] pop_word(input logic [WORD_BITS-1:0] v);
      logic [BPOS_W:0] s;
      s = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         s = s + (BPOS_W+1)'(v[i]);
      end
      return s;
   endfunction

   // {hit, lowest set position}
   function automatic logic [BPOS_W:0] find_first(input logic [WORD_BITS-1:0] v);
      logic [BPOS_W:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, BPOS_W'(i)};
         end
      end
      return r;
   endfunction

   // {hit, highest set position}
   function automatic logic [BPOS_W:0] find_last(input logic [WORD_BITS-1:0] v);
      logic [BPOS_W:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) begin
            r = {1'b1, BPOS_W'(i)};
         end
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/bra_req_if.sv
`default_nettype none
interface bra_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [11:0] index;
   logic [12:0] length;
   modport source (output valid, operation, index, length, input ready);
   modport sink (input valid, operation, index, length, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bra_rsp_if.sv
`default_nettype none
interface bra_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [11:0] position;
   logic [12:0] bit_count;
   logic        all_set;
   logic        all_clear;
   logic        range_error;
   modport source (output valid, found, position, bit_count, all_set, all_clear,
                   range_error, input ready);
   modport sink (input valid, found, position, bit_count, all_set, all_clear,
                 range_error, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bra_store.sv
`default_nettype none
module bra_store
   import bra_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire store_req_type        sreq,
   output logic [WORD_BITS-1:0]      rd_word
);
   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_ff;
   logic                  rdv_ff;

   always_ff @(posedge clock) begin
      if (sreq.wr_en) begin
         mem[sreq.addr] <= sreq.wdata;
      end
      if (sreq.rd_en) begin
         rd_ff <= mem[sreq.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         if (sreq.wr_en) begin
            valid_ff[sreq.addr] <= 1'b1;
         end
         if (sreq.rd_en) begin
            rdv_ff <= valid_ff[sreq.addr];
         end
      end
   end

   assign rd_word = rdv_ff ? rd_ff : '0;
endmodule
`default_nettype wire

// File: hw/rtl/bra_engine.sv
`default_nettype none
module bra_engine
   import bra_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [PTR_W-1:0]     size_raw,
   bra_req_if.sink                   req,
   bra_rsp_if.source                 rsp,
   output store_req_type             sreq,
   input  wire logic [WORD_BITS-1:0] rd_word
);
   localparam logic [PTR_W-1:0] MAP_SIZE = PTR_W'(MAP_BITS);
   localparam logic [PTR_W:0]   WMASK    = (PTR_W+1)'(WORD_BITS - 1);

   state_type             state_ff, state_in, step_state;
   mode_type              mode_ff, mode_in;
   op_type                op_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [PTR_W-1:0]      hi_ff, hi_in;
   logic [PTR_W-1:0]      run_ff, run_in;
   logic [IDX_W-1:0]      first_ff, first_in;
   logic                  pass_ff, pass_in;
   logic                  want_ff, want_in;
   logic                  wv_ff, wv_in;
   logic [WORD_BITS-1:0]  wd_ff;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic                  aset_ff, aset_in;
   logic                  aclr_ff, aclr_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_load;

   logic [PTR_W-1:0]      size;
   logic [PTR_W:0]        hi_raw, hi_all;
   logic                  rng_err;
   logic [PTR_W-1:0]      hi_c, lo_c, idx_p1;
   logic [PTR_W-1:0]      aptr, base, wend, seg_end, pend_raw, pend, seg;
   logic [WADDR_W-1:0]    waddr;
   logic [WORD_BITS-1:0]  lomask, himask, rmask, lmask, sel, diff;
   logic                  bi;
   logic [BPOS_W:0]       ff_r, fl_r, fd_r;
   logic [PTR_W:0]        newrun;
   logic [IDX_W-1:0]      frun;

   assign size    = (size_raw > MAP_SIZE) ? MAP_SIZE : size_raw;
   assign hi_raw  = {2'b0, idx_ff} + {1'b0, len_ff};
   assign rng_err = 1'b0;

   always_comb begin
      aptr    = (mode_ff == MD_LAST) ? ptr_ff - PTR_W'(1) : ptr_ff;
      waddr   = aptr[PTR_W-2:BPOS_W];
      base    = {1'b0, waddr, BPOS_W'(0)};
      wend    = base + PTR_W'(WORD_BITS);
      seg_end = (wend < hi_ff) ? wend : hi_ff;
      lomask  = {WORD_BITS{1'b1}} << ptr_ff[BPOS_W-1:0];
      himask  = (seg_end == wend) ? {WORD_BITS{1'b1}}
                : ~({WORD_BITS{1'b1}} << seg_end[BPOS_W-1:0]);
      rmask   = lomask & himask;
      lmask   = (ptr_ff == wend) ? {WORD_BITS{1'b1}}
                : ~({WORD_BITS{1'b1}} << ptr_ff[BPOS_W-1:0]);
      sel     = want_ff ? wd_ff : ~wd_ff;
      ff_r    = find_first(sel & rmask);
      fl_r    = find_last(sel & lmask);
      bi      = wd_ff[ptr_ff[BPOS_W-1:0]];
      diff    = (wd_ff ^ {WORD_BITS{bi}}) & lomask;
      fd_r    = find_first(diff);
      pend_raw = fd_r[BPOS_W] ? {1'b0, waddr, fd_r[BPOS_W-1:0]} : wend;
      pend    = (pend_raw < hi_ff) ? pend_raw : hi_ff;
      seg     = pend - ptr_ff;
      newrun  = {1'b0, run_ff} + {1'b0, seg};
      frun    = (run_ff == '0) ? ptr_ff[IDX_W-1:0] : first_ff;
   end

   always_comb begin
      logic [PTR_W-1:0] hsel;
      logic [PTR_W:0]   hsum;
      hsel    = (hi_raw > {1'b0, size}) ? size : hi_raw[PTR_W-1:0];
      hsum    = {1'b0, size} + WMASK;
      hi_all  = hsum & ~WMASK;
      hi_c    = hsel;
      lo_c    = ({1'b0, idx_ff} > hi_c) ? hi_c : {1'b0, idx_ff};
      idx_p1  = {1'b0, idx_ff} + PTR_W'(1);
   end

   // Work-item datapath and per-step decisions.
   always_comb begin
      logic [PTR_W:0] hr;
      logic           re;
      hr         = {2'b0, idx_ff} + {1'b0, len_ff};
      re         = hr > {1'b0, size};
      step_state = state_ff;
      mode_in    = mode_ff;
      ptr_in     = ptr_ff;
      hi_in      = hi_ff;
      run_in     = run_ff;
      first_in   = first_ff;
      pass_in    = pass_ff;
      want_in    = want_ff;
      wv_in      = wv_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      aset_in    = aset_ff;
      aclr_in    = aclr_ff;
      err_in     = err_ff;
      sreq       = '0;
      sreq.addr  = waddr;
      sreq.wdata = wv_ff ? (wd_ff | rmask) : (wd_ff & ~rmask);
      unique case (state_ff)
         ST_START: begin
            found_in = 1'b0;
            pos_in   = '0;
            count_in = '0;
            aset_in  = 1'b0;
            aclr_in  = 1'b0;
            run_in   = '0;
            pass_in  = 1'b1;
            hi_in    = size;
            ptr_in   = '0;
            err_in   = 1'b0;
            want_in  = 1'b0;
            wv_in    = 1'b0;
            step_state = ST_RD;
            unique case (op_ff)
               OP_TEST: begin
                  mode_in = MD_TEST;
                  err_in  = {1'b0, idx_ff} >= size;
                  ptr_in  = {1'b0, idx_ff};
                  if ({1'b0, idx_ff} >= size) begin
                     step_state = ST_FIN;
                  end
               end
               OP_SET_RANGE, OP_CLEAR_RANGE: begin
                  mode_in = MD_WRITE;
                  err_in  = re;
                  wv_in   = (op_ff == OP_SET_RANGE);
                  ptr_in  = lo_c;
                  hi_in   = hi_c;
                  if (lo_c >= hi_c) begin
                     step_state = ST_FIN;
                  end
               end
               OP_SET_ALL, OP_CLEAR_ALL: begin
                  mode_in = MD_WRITE;
                  wv_in   = (op_ff == OP_SET_ALL);
                  hi_in   = hi_all[PTR_W-1:0];
                  if (hi_all == '0) begin
                     step_state = ST_FIN;
                  end
               end
               OP_FIND_CLEAR, OP_FIND_SET, OP_CLAIM: begin
                  mode_in = MD_RUN;
                  want_in = (op_ff == OP_FIND_SET);
                  err_in  = (len_ff > size) || ({1'b0, idx_ff} >= size);
                  if (!(({1'b0, idx_ff} >= size) || (idx_ff == '0))) begin
                     ptr_in  = {1'b0, idx_ff};
                     pass_in = 1'b0;
                  end
                  if ((len_ff == '0) || (len_ff > size)) begin
                     step_state = ST_FIN;
                  end
               end
               OP_FIRST_SET, OP_FIRST_CLEAR: begin
                  mode_in = MD_FIRST;
                  want_in = (op_ff == OP_FIRST_SET);
                  if (size == '0) begin
                     step_state = ST_FIN;
                  end
               end
               OP_LAST_SET, OP_LAST_CLEAR: begin
                  mode_in = MD_LAST;
                  want_in = (op_ff == OP_LAST_SET);
                  ptr_in  = size;
                  if (size == '0) begin
                     step_state = ST_FIN;
                  end
               end
               OP_NEXT_SET, OP_NEXT_CLEAR: begin
                  mode_in = MD_FIRST;
                  want_in = (op_ff == OP_NEXT_SET);
                  err_in  = {1'b0, idx_ff} >= size;
                  ptr_in  = idx_p1;
                  if (idx_p1 >= size) begin
                     step_state = ST_FIN;
                  end
               end
               OP_COUNT, OP_CHECK: begin
                  mode_in = MD_COUNT;
                  err_in  = re;
                  aset_in = 1'b1;
                  aclr_in = 1'b1;
                  ptr_in  = lo_c;
                  hi_in   = hi_c;
                  if (lo_c >= hi_c) begin
                     step_state = ST_FIN;
                  end
               end
            endcase
         end
         ST_RD: begin
            sreq.rd_en = 1'b1;
            step_state = ST_LD;
         end
         ST_LD: begin
            step_state = ST_EX;
         end
         ST_EX: begin
            unique case (mode_ff)
               MD_TEST: begin
                  found_in   = bi;
                  pos_in     = bi ? idx_ff : '0;
                  step_state = ST_FIN;
               end
               MD_WRITE: begin
                  sreq.wr_en = 1'b1;
                  ptr_in     = seg_end;
                  step_state = (seg_end >= hi_ff) ? ST_FIN : ST_RD;
               end
               MD_COUNT: begin
                  count_in = count_ff + LEN_W'(pop_word(wd_ff & rmask));
                  if ((wd_ff & rmask) != '0) begin
                     aclr_in = 1'b0;
                  end
                  if ((wd_ff & rmask) != rmask) begin
                     aset_in = 1'b0;
                  end
                  ptr_in     = seg_end;
                  step_state = (seg_end >= hi_ff) ? ST_FIN : ST_RD;
               end
               MD_FIRST: begin
                  if (ff_r[BPOS_W]) begin
                     found_in   = 1'b1;
                     pos_in     = {waddr, ff_r[BPOS_W-1:0]};
                     step_state = ST_FIN;
                  end else begin
                     ptr_in     = seg_end;
                     step_state = (seg_end >= hi_ff) ? ST_FIN : ST_RD;
                  end
               end
               MD_LAST: begin
                  if (fl_r[BPOS_W]) begin
                     found_in   = 1'b1;
                     pos_in     = {waddr, fl_r[BPOS_W-1:0]};
                     step_state = ST_FIN;
                  end else begin
                     ptr_in     = base;
                     step_state = (base == '0) ? ST_FIN : ST_RD;
                  end
               end
               MD_RUN: begin
                  if ((bi == want_ff) && (newrun >= {1'b0, len_ff})) begin
                     found_in = 1'b1;
                     pos_in   = frun;
                     if (op_ff == OP_CLAIM) begin
                        mode_in    = MD_WRITE;
                        wv_in      = 1'b1;
                        ptr_in     = {1'b0, frun};
                        hi_in      = {1'b0, frun} + len_ff;
                        step_state = ST_RD;
                     end else begin
                        step_state = ST_FIN;
                     end
                  end else begin
                     if (bi == want_ff) begin
                        run_in   = newrun[PTR_W-1:0];
                        first_in = frun;
                     end else begin
                        run_in = '0;
                     end
                     ptr_in = pend;
                     if (pend >= hi_ff) begin
                        if (!pass_ff) begin
                           pass_in    = 1'b1;
                           ptr_in     = '0;
                           run_in     = '0;
                           step_state = ST_RD;
                        end else begin
                           step_state = ST_FIN;
                        end
                     end else if (pend == wend) begin
                        step_state = ST_RD;
                     end else begin
                        step_state = ST_EX;
                     end
                  end
               end
               default: step_state = ST_FIN;
            endcase
         end
         default: ;
      endcase
   end

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_START;
         ST_FIN:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = step_state;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MD_TEST;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req.valid) begin
         op_ff  <= op_type'(req.operation);
         idx_ff <= req.index;
         len_ff <= req.length;
      end
      if (state_ff == ST_LD) begin
         wd_ff <= rd_word;
      end
      ptr_ff   <= ptr_in;
      hi_ff    <= hi_in;
      run_ff   <= run_in;
      first_ff <= first_in;
      pass_ff  <= pass_in;
      want_ff  <= want_in;
      wv_ff    <= wv_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      count_ff <= count_in;
      aset_ff  <= aset_in;
      aclr_ff  <= aclr_in;
      err_ff   <= err_in;
      if (rsp_load) begin
         rsp.found       <= found_ff;
         rsp.position    <= found_ff ? pos_ff : '0;
         rsp.bit_count   <= count_ff;
         rsp.all_set     <= aset_ff;
         rsp.all_clear   <= aclr_ff;
         rsp.range_error <= err_ff;
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !rng_err;
   assign rsp.valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bitmap_run_allocator.sv
`default_nettype none
// Bitmap run allocator: a 4096-bit store held as 64 words of 64 bits in one
// synchronous RAM, cleared at reset through per-word valid bits (no clearing
// pass; requests are taken right after reset). One request is worked at a time
// by a read/modify/write sequencer: each word visited passes through read, load
// and operate steps, plus one more operate step per extra run segment inside a
// word during run searches, then a final step posts the response. A run search
// makes up to two sweeps of the store. A new request is taken while the previous
// response is still waiting.
// csr_wr_data sets the bits in use; values above 4096 act as 4096.
module bitmap_run_allocator
   import bra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   bra_req_if.sink                req_chan,
   bra_rsp_if.source              rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [PTR_W-1:0]  csr_wr_data
);
   logic [PTR_W-1:0]     size_ff;
   store_req_type        sreq;
   logic [WORD_BITS-1:0] rd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= PTR_W'(MAP_BITS);
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   bra_store u_store (
      .clock   (clock),
      .reset   (reset),
      .sreq    (sreq),
      .rd_word (rd_word)
   );

   bra_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .size_raw (size_ff),
      .req      (req_chan),
      .rsp      (rsp_chan),
      .sreq     (sreq),
      .rd_word  (rd_word)
   );
endmodule
`default_nettype wire

// File: hw/rtl/bra_checker.sv
`default_nettype none
`include "bitmap_run_allocator_macros.svh"
module bra_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [11:0] rsp_position,
   input wire logic [12:0] rsp_bit_count,
   input wire logic        rsp_all_set,
   input wire logic        rsp_all_clear
);
   `BRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BRA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `BRA_ASSERT_NOW(a_pos_zero, clock, reset, rsp_valid && !rsp_found, rsp_position == '0)
   `BRA_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && rsp_all_set && rsp_all_clear,
      rsp_bit_count == '0)
endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.found),
   .rsp_position  (rsp_chan.position),
   .rsp_bit_count (rsp_chan.bit_count),
   .rsp_all_set   (rsp_chan.all_set),
   .rsp_all_clear (rsp_chan.all_clear)
);
`default_nettype wire
